// File: hw/rtl/csfe_pkg.sv
// Shared types and constants for the clipped shape fill engine.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package csfe_pkg;

    // Command codes
    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_PIXEL = 3'd1;
    localparam logic [2:0] OP_RECT  = 3'd2;
    localparam logic [2:0] OP_TRIUP = 3'd3;
    localparam logic [2:0] OP_TRIDN = 3'd4;
    localparam logic [2:0] OP_DIAM  = 3'd5;
    localparam logic [2:0] OP_READ  = 3'd6;

    // Configuration register indexes (byte address 4 * index)
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;
    localparam int   PAW        = 3;

    // Character codes
    localparam logic [7:0] DOT_CHAR   = 8'd46;
    localparam logic [7:0] SPACE_CHAR = 8'd32;
    localparam logic [7:0] DIGIT_ZERO = 8'd48;

    // Signed coordinate width: covers origin +/- 254 and origin + 2 * 127
    localparam int CW = 11;
    // Effective canvas size width: 0..256
    localparam int EW = 9;

    typedef struct packed {
        logic [2:0]        opcode;
        logic signed [7:0] pos_x;
        logic signed [7:0] pos_y;
        logic [6:0]        size_w;
        logic [6:0]        size_h;
        logic [7:0]        brush_char;
    } t_cmd;

    typedef struct packed {
        logic [7:0] read_char;
        logic       hit;
    } t_result;

    // Effective (saturated) canvas size
    typedef struct packed {
        logic [EW-1:0] w;
        logic [EW-1:0] h;
    } t_canvas;

    // Command completion from the sequencer to the view stage
    typedef struct packed {
        logic              done;
        logic              is_read;
        logic signed [7:0] pos_x;
        logic signed [7:0] pos_y;
    } t_fin;

    // Remainder by ten of a value below 128, by restoring subtraction
    function automatic logic [3:0] mod10(input logic [6:0] v);
        logic [6:0] t;
        t = v;
        if (t >= 7'd80) t = t - 7'd80;
        if (t >= 7'd40) t = t - 7'd40;
        if (t >= 7'd20) t = t - 7'd20;
        if (t >= 7'd10) t = t - 7'd10;
        return t[3:0];
    endfunction

endpackage

// File: hw/rtl/clipped_shape_fill_engine.sv
// Top level of the clipped shape fill engine: character frame store with fills.
// Depends on csfe_pkg, csfe_cfg, csfe_store, csfe_seq and csfe_view.
//
//  Port group        Direction  Handshake                     Payload
//  command           in         start, busy (taken if !busy)  i_cmd (t_cmd)
//  result            out        o_strobe, one cycle           o_result (t_result)
//  configuration     in/out     APB psel/penable/pwrite       paddr, pwdata, prdata
//
// A clear sweeps every cell of the store; a shape walks its rows and writes each clipped
// cell; a read fetches one cell. busy falls in the strobe cycle. The store's single write
// port, one cell per cycle, paces clears and shape fills.
// Reset and every register write run a clearing pass over all MAX_COLS*MAX_ROWS cells with
// busy high; register writes are still taken meanwhile.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
module clipped_shape_fill_engine import csfe_pkg::*; #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  t_cmd           i_cmd,
    output logic           o_strobe,
    output t_result        o_result,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [PAW-1:0] paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    logic          cfg_wr;
    t_canvas       canvas;
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;
    t_fin          fin;

    csfe_cfg #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg_wr (cfg_wr),
        .o_canvas (canvas)
    );

    csfe_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    csfe_seq #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .AW       (AW)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_cmd    (i_cmd),
        .i_cfg_wr (cfg_wr),
        .i_canvas (canvas),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_re     (re),
        .o_raddr  (raddr),
        .o_fin    (fin)
    );

    csfe_view u_view (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fin    (fin),
        .i_canvas (canvas),
        .i_rdata  (rdata),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// File: hw/rtl/csfe_cfg.sv
// APB register file for the canvas size, with saturation to the store size.
// Depends on csfe_pkg.
`timescale 1ns / 1ps
module csfe_cfg import csfe_pkg::*; #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [PAW-1:0] paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output logic           o_cfg_wr,
    output t_canvas        o_canvas
);

    logic [6:0] r_width;
    logic [6:0] r_height;
    logic       wr;

    assign pready   = 1'b1;
    assign wr       = psel & penable & pwrite;
    assign o_cfg_wr = wr;

    // Take register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 7'd64;
            r_height <= 7'd64;
        end else if (wr) begin
            unique case (paddr[2])
                REG_WIDTH:  r_width  <= pwdata[6:0];
                REG_HEIGHT: r_height <= pwdata[6:0];
                default:    ;
            endcase
        end
    end

    // Return register values
    always_comb begin
        prdata = 32'd0;
        unique case (paddr[2])
            REG_WIDTH:  prdata = {25'd0, r_width};
            REG_HEIGHT: prdata = {25'd0, r_height};
            default:    prdata = 32'd0;
        endcase
    end

    // Saturate to the store dimensions
    assign o_canvas.w = ({2'b00, r_width} > EW'(MAX_COLS)) ? EW'(MAX_COLS)
                                                           : {2'b00, r_width};
    assign o_canvas.h = ({2'b00, r_height} > EW'(MAX_ROWS)) ? EW'(MAX_ROWS)
                                                            : {2'b00, r_height};

endmodule

// File: hw/rtl/csfe_store.sv
// Frame store: single write port, single read port, registered read data.
// Depends on csfe_pkg.
`timescale 1ns / 1ps
module csfe_store import csfe_pkg::*; #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    // Write one cell
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read one cell, data the next cycle
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/csfe_seq.sv
// Command sequencer: clearing sweep, row/column walk of clipped shapes, reads.
// Depends on csfe_pkg; drives the ports of csfe_store.
`timescale 1ns / 1ps
module csfe_seq import csfe_pkg::*; #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64,
    parameter int AW       = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  t_cmd          i_cmd,
    input  logic          i_cfg_wr,
    input  t_canvas       i_canvas,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [7:0]    o_wdata,
    output logic          o_re,
    output logic [AW-1:0] o_raddr,
    output t_fin          o_fin
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CLW   = $clog2(MAX_COLS);
    localparam logic signed [CW-1:0] ONE = 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_ROW   = 3'd2;
    localparam logic [2:0] ST_COL   = 3'd3;
    localparam logic [2:0] ST_RDA   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]           r_state,  n_state;
    logic [AW-1:0]        r_cnt,    n_cnt;
    logic                 r_report, n_report;
    logic                 r_is_read, n_is_read;
    logic                 r_rect,   n_rect;
    logic                 r_down,   n_down;
    logic                 r_diam,   n_diam;
    logic signed [CW-1:0] r_ox,     n_ox;
    logic signed [CW-1:0] r_row,    n_row;
    logic [6:0]           r_half,   n_half;
    logic [7:0]           r_i,      n_i;
    logic [7:0]           r_nrows,  n_nrows;
    logic [6:0]           r_sh,     n_sh;
    logic [6:0]           r_sw,     n_sw;
    logic [7:0]           r_brush,  n_brush;
    logic signed [CW-1:0] r_col,    n_col;
    logic signed [CW-1:0] r_col_hi, n_col_hi;
    logic [AW-1:0]        r_base,   n_base;
    logic signed [7:0]    r_px,     n_px;
    logic signed [7:0]    r_py,     n_py;

    logic signed [CW-1:0] w_s, h_s, half_s, sw_s;
    logic signed [CW-1:0] lo, hi, lo_c, hi_c;
    logic signed [CW-1:0] row_m1, col_m1, px_m1, py_m1;
    logic signed [CW-1:0] px_s, py_s;
    logic                 row_ok, last_row;
    logic [AW-1:0]        row_base;

    assign o_busy = (r_state != ST_IDLE) | i_cfg_wr;

    // Clip the current row's span to the canvas
    always_comb begin
        w_s    = $signed(CW'(i_canvas.w));
        h_s    = $signed(CW'(i_canvas.h));
        half_s = $signed(CW'(r_half));
        sw_s   = $signed(CW'(r_sw));
        if (r_rect) begin
            lo = r_ox;
            hi = r_ox + sw_s - ONE;
        end else begin
            lo = r_ox - half_s;
            hi = r_ox + half_s;
        end
        lo_c     = (lo < ONE) ? ONE : lo;
        hi_c     = (hi > w_s) ? w_s : hi;
        row_ok   = (r_row >= ONE) && (r_row <= h_s) && (lo_c <= hi_c);
        last_row = (r_i == r_nrows - 8'd1);
        row_m1   = r_row - ONE;
        row_base = AW'(row_m1[RW-1:0]) * AW'(MAX_COLS);
        col_m1   = r_col - ONE;
        px_s     = CW'(i_cmd.pos_x);
        py_s     = CW'(i_cmd.pos_y);
        px_m1    = CW'(r_px) - ONE;
        py_m1    = CW'(r_py) - ONE;
    end

    // Drive the store ports
    always_comb begin
        o_we    = 1'b0;
        o_waddr = r_base + AW'(col_m1[CLW-1:0]);
        o_wdata = r_brush;
        if (r_state == ST_CLEAR) begin
            o_we    = 1'b1;
            o_waddr = r_cnt;
            o_wdata = DOT_CHAR;
        end else if (r_state == ST_COL) begin
            o_we = 1'b1;
        end
        o_re    = (r_state == ST_RDA);
        o_raddr = AW'(py_m1[RW-1:0]) * AW'(MAX_COLS) + AW'(px_m1[CLW-1:0]);
    end

    assign o_fin.done    = (r_state == ST_DONE);
    assign o_fin.is_read = r_is_read;
    assign o_fin.pos_x   = r_px;
    assign o_fin.pos_y   = r_py;

    // Next-state logic
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_report  = r_report;
        n_is_read = r_is_read;
        n_rect    = r_rect;
        n_down    = r_down;
        n_diam    = r_diam;
        n_ox      = r_ox;
        n_row     = r_row;
        n_half    = r_half;
        n_i       = r_i;
        n_nrows   = r_nrows;
        n_sh      = r_sh;
        n_sw      = r_sw;
        n_brush   = r_brush;
        n_col     = r_col;
        n_col_hi  = r_col_hi;
        n_base    = r_base;
        n_px      = r_px;
        n_py      = r_py;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    // Latch the command and set up the walk
                    n_is_read = (i_cmd.opcode == OP_READ);
                    n_px      = i_cmd.pos_x;
                    n_py      = i_cmd.pos_y;
                    n_brush   = i_cmd.brush_char;
                    n_sh      = i_cmd.size_h;
                    n_sw      = i_cmd.size_w;
                    n_ox      = px_s + ONE;
                    n_row     = py_s + ONE;
                    n_half    = 7'd0;
                    n_i       = 8'd0;
                    n_rect    = 1'b0;
                    n_down    = 1'b0;
                    n_diam    = 1'b0;
                    n_nrows   = {1'b0, i_cmd.size_h};
                    case (i_cmd.opcode)
                        OP_CLEAR: begin
                            n_cnt    = '0;
                            n_report = 1'b1;
                        end
                        OP_PIXEL: begin
                            n_ox    = px_s;
                            n_row   = py_s;
                            n_sw    = 7'd1;
                            n_rect  = 1'b1;
                            n_nrows = 8'd1;
                        end
                        OP_RECT: begin
                            n_rect = 1'b1;
                            if (i_cmd.size_w == 7'd0) n_nrows = 8'd0;
                        end
                        OP_TRIDN: n_down = 1'b1;
                        OP_DIAM: begin
                            n_diam  = 1'b1;
                            n_nrows = {i_cmd.size_h, 1'b0} + 8'd1;
                        end
                        default: ;
                    endcase
                    case (i_cmd.opcode) inside
                        OP_CLEAR: n_state = ST_CLEAR;
                        OP_READ:  n_state = ST_RDA;
                        OP_PIXEL, OP_RECT, OP_TRIUP, OP_TRIDN, OP_DIAM:
                            n_state = (n_nrows == 8'd0) ? ST_DONE : ST_ROW;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR: begin
                // Sweep the whole store with dots
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == AW'(DEPTH - 1)) begin
                    n_state = r_report ? ST_DONE : ST_IDLE;
                end
            end
            ST_ROW: begin
                if (row_ok) begin
                    n_col    = lo_c;
                    n_col_hi = hi_c;
                    n_base   = row_base;
                    n_state  = ST_COL;
                end else if (last_row) begin
                    n_state = ST_DONE;
                end else begin
                    n_i    = r_i + 8'd1;
                    n_row  = r_down ? r_row - ONE : r_row + ONE;
                    n_half = (r_diam && r_i >= {1'b0, r_sh}) ? r_half - 7'd1
                                                             : r_half + 7'd1;
                end
            end
            ST_COL: begin
                // One cell per cycle; advance row at span end
                n_col = r_col + ONE;
                if (r_col == r_col_hi) begin
                    if (last_row) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_ROW;
                        n_i     = r_i + 8'd1;
                        n_row   = r_down ? r_row - ONE : r_row + ONE;
                        n_half  = (r_diam && r_i >= {1'b0, r_sh}) ? r_half - 7'd1
                                                                  : r_half + 7'd1;
                    end
                end
            end
            ST_RDA:  n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase

        // A resize restarts the clearing sweep
        if (i_cfg_wr) begin
            n_state  = ST_CLEAR;
            n_cnt    = '0;
            n_report = (r_state == ST_CLEAR) && r_report;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_cnt    <= '0;
            r_report <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_report <= n_report;
        end
    end

    // Walk registers
    always_ff @(posedge i_clk) begin
        r_is_read <= n_is_read;
        r_rect    <= n_rect;
        r_down    <= n_down;
        r_diam    <= n_diam;
        r_ox      <= n_ox;
        r_row     <= n_row;
        r_half    <= n_half;
        r_i       <= n_i;
        r_nrows   <= n_nrows;
        r_sh      <= n_sh;
        r_sw      <= n_sw;
        r_brush   <= n_brush;
        r_col     <= n_col;
        r_col_hi  <= n_col_hi;
        r_base    <= n_base;
        r_px      <= n_px;
        r_py      <= n_py;
    end

endmodule

// File: hw/rtl/csfe_view.sv
// Result stage: forms the printed view of a read and registers each result.
// Depends on csfe_pkg.
`timescale 1ns / 1ps
module csfe_view import csfe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_fin       i_fin,
    input  t_canvas    i_canvas,
    input  logic [7:0] i_rdata,
    output logic       o_strobe,
    output t_result    o_result
);

    logic              r_strobe;
    t_result           r_result;
    logic signed [9:0] px_e, py_e, w_e, h_e;
    logic [7:0]        px_m1, py_m1;
    logic              hit;
    logic [7:0]        rchar;

    // Classify the read position
    always_comb begin
        px_e  = 10'($signed(i_fin.pos_x));
        py_e  = 10'($signed(i_fin.pos_y));
        w_e   = $signed(10'(i_canvas.w));
        h_e   = $signed(10'(i_canvas.h));
        px_m1 = i_fin.pos_x - 8'd1;
        py_m1 = i_fin.pos_y - 8'd1;
        hit   = i_fin.is_read && (px_e >= 10'sd0) && (px_e <= w_e)
                && (py_e >= 10'sd0) && (py_e <= h_e);
        rchar = 8'd0;
        if (hit) begin
            if (px_e == 10'sd0 && py_e == 10'sd0) begin
                rchar = SPACE_CHAR;
            end else if (py_e == 10'sd0) begin
                rchar = DIGIT_ZERO + 8'(mod10(px_m1[6:0]));
            end else if (px_e == 10'sd0) begin
                rchar = DIGIT_ZERO + 8'(mod10(py_m1[6:0]));
            end else begin
                rchar = i_rdata;
            end
        end
    end

    // Strobe for one cycle per finished item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_fin.done;
        end
    end

    // Hold the payload between items
    always_ff @(posedge i_clk) begin
        if (i_fin.done) begin
            r_result.read_char <= rchar;
            r_result.hit       <= hit;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// File: test/csfe_result_checker.sv
// Result checker for the clipped shape fill engine: mirrors the frame store and canvas size.
// Watches the command, result and register channels; depends on csfe_pkg only.
`timescale 1ns / 1ps
module csfe_result_checker import csfe_pkg::*; #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  t_cmd           i_cmd,
    input  logic           i_strobe,
    input  t_result        i_result,
    input  logic           i_psel,
    input  logic           i_penable,
    input  logic           i_pwrite,
    input  logic [PAW-1:0] i_paddr,
    input  logic [31:0]    i_pwdata,
    input  logic [31:0]    i_prdata,
    input  logic           i_pready,
    output int             o_fail_count,
    output int             o_pending
);

    logic [7:0] frame_cells [MAX_COLS*MAX_ROWS];
    logic [6:0] width_reg = 7'd64;
    logic [6:0] height_reg = 7'd64;
    t_result    expected_results [$];
    int         fail_count = 0;
    int         pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // Drawable size: register value saturated to the store dimensions
    function automatic int drawable_cols();
        return (width_reg > MAX_COLS) ? MAX_COLS : int'(width_reg);
    endfunction

    function automatic int drawable_rows();
        return (height_reg > MAX_ROWS) ? MAX_ROWS : int'(height_reg);
    endfunction

    function automatic void wipe_frame();
        foreach (frame_cells[k]) frame_cells[k] = DOT_CHAR;
    endfunction

    // Append one expectation behind the ones still waiting
    function automatic void queue_expected(input t_result r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Drop any write outside columns 1..width and rows 1..height
    function automatic void paint_cell(input int x, input int y, input logic [7:0] ch);
        if (x >= 1 && x <= drawable_cols() && y >= 1 && y <= drawable_rows()) begin
            frame_cells[(y - 1) * MAX_COLS + (x - 1)] = ch;
        end
    endfunction

    function automatic void paint_span(input int cx, input int row, input int half,
                                       input logic [7:0] ch);
        int j;
        for (j = -half; j <= half; j++) paint_cell(cx + j, row, ch);
    endfunction

    // Apply one command to the mirrored store and return the result it produces
    function automatic t_result run_command(input t_cmd c);
        int      px, py, sw, sh, ox, oy, i, j;
        t_result res;
        px  = $signed(c.pos_x);
        py  = $signed(c.pos_y);
        sw  = int'(c.size_w);
        sh  = int'(c.size_h);
        ox  = px + 1;
        oy  = py + 1;
        res = '0;
        case (c.opcode)
            OP_CLEAR: wipe_frame();
            OP_PIXEL: paint_cell(px, py, c.brush_char);
            OP_RECT: begin
                for (i = 0; i < sh; i++)
                    for (j = 0; j < sw; j++) paint_cell(ox + j, oy + i, c.brush_char);
            end
            OP_TRIUP: begin
                for (i = 0; i < sh; i++) paint_span(ox, oy + i, i, c.brush_char);
            end
            OP_TRIDN: begin
                for (i = 0; i < sh; i++) paint_span(ox, oy - i, i, c.brush_char);
            end
            OP_DIAM: begin
                for (i = 0; i <= 2 * sh; i++)
                    paint_span(ox, oy + i, (i <= sh) ? i : 2 * sh - i, c.brush_char);
            end
            OP_READ: begin
                // Printed view: index line on row 0 and column 0, store inside
                if (px >= 0 && px <= drawable_cols() && py >= 0 && py <= drawable_rows()) begin
                    res.hit = 1'b1;
                    if (px == 0 && py == 0) res.read_char = SPACE_CHAR;
                    else if (py == 0)       res.read_char = DIGIT_ZERO + 8'((px - 1) % 10);
                    else if (px == 0)       res.read_char = DIGIT_ZERO + 8'((py - 1) % 10);
                    else res.read_char = frame_cells[(py - 1) * MAX_COLS + (px - 1)];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < 40) begin
            $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
        end
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_result    want;
        logic [6:0] reg_value;
        if (!i_rst_n) begin
            width_reg  = 7'd64;
            height_reg = 7'd64;
            wipe_frame();
            expected_results.delete();
        end else begin
            // Compare the item on the result port with the oldest expectation
            if (i_strobe) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with none pending, read_char",
                                    int'(i_result.read_char), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_result.read_char !== want.read_char)
                        report_mismatch("read_char", int'(i_result.read_char),
                                        int'(want.read_char));
                    if (i_result.hit !== want.hit)
                        report_mismatch("hit", int'(i_result.hit), int'(want.hit));
                end
            end
            // Track register writes, each one starts a blank canvas; check reads
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr[PAW-1:2])
                        REG_WIDTH: begin
                            width_reg = i_pwdata[6:0];
                            wipe_frame();
                        end
                        REG_HEIGHT: begin
                            height_reg = i_pwdata[6:0];
                            wipe_frame();
                        end
                        default: ;
                    endcase
                end else begin
                    reg_value = (i_paddr[PAW-1:2] == REG_WIDTH) ? width_reg : height_reg;
                    if (i_prdata !== {25'd0, reg_value})
                        report_mismatch("register read", int'(i_prdata), int'(reg_value));
                end
            end
            // Predict the item taken at this edge
            if (i_start && !i_busy) queue_expected(run_command(i_cmd));
        end
        pending_count = expected_results.size();
    end

endmodule

// File: test/clipped_shape_fill_engine_test.sv
// Testbench top for the clipped shape fill engine: reset, register setup and commands.
// Depends on csfe_pkg, the engine RTL and csfe_result_checker, which gives the fail count.
`timescale 1ns / 1ps
module clipped_shape_fill_engine_test;
    import csfe_pkg::*;

    localparam int         MAX_COLS      = 64;
    localparam int         MAX_ROWS      = 64;
    localparam int         CYCLE_LIMIT   = 4_000_000;
    localparam int         SETTLE_CYCLES = 64;
    localparam int         PHASE_ITEMS   = 18;
    localparam logic [2:0] OP_UNUSED     = 3'd7;

    logic           i_clk    = 1'b0;
    logic           i_rst_n  = 1'b0;
    logic           start    = 1'b0;
    logic           busy;
    t_cmd           cmd_item = '0;
    logic           o_strobe;
    t_result        o_result;
    logic           psel     = 1'b0;
    logic           penable  = 1'b0;
    logic           pwrite   = 1'b0;
    logic [PAW-1:0] paddr    = '0;
    logic [31:0]    pwdata   = '0;
    logic [31:0]    prdata;
    logic           pready;

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int idle_pct    = 0;
    int last_x      = 0;
    int last_y      = 0;
    int cols_now    = 64;
    int rows_now    = 64;

    always #2 i_clk = ~i_clk;

    clipped_shape_fill_engine #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (cmd_item),
        .o_strobe(o_strobe),
        .o_result(o_result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    csfe_result_checker #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) u_result_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_cmd       (cmd_item),
        .i_strobe    (o_strobe),
        .i_result    (o_result),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .o_fail_count(fail_count),
        .o_pending   (pending_count)
    );

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_cmd make_cmd(input logic [2:0] op, input int x, input int y,
                                      input int sw, input int sh, input logic [7:0] br);
        t_cmd c;
        c.opcode     = op;
        c.pos_x      = 8'(x);
        c.pos_y      = 8'(y);
        c.size_w     = 7'(sw);
        c.size_h     = 7'(sh);
        c.brush_char = br;
        return c;
    endfunction

    // Mostly around the canvas, sometimes anywhere in the signed range
    function automatic int near_coord(input int limit);
        if ($urandom_range(0, 99) < 85) return int'($urandom_range(0, limit + 3)) - 2;
        return int'($urandom_range(0, 255)) - 128;
    endfunction

    function automatic int shape_size();
        if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 127));
        return int'($urandom_range(0, 8));
    endfunction

    function automatic t_cmd random_draw();
        int         pick, x, y;
        logic [2:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 4)       op = OP_CLEAR;
        else if (pick < 20) op = OP_PIXEL;
        else if (pick < 42) op = OP_RECT;
        else if (pick < 58) op = OP_TRIUP;
        else if (pick < 74) op = OP_TRIDN;
        else if (pick < 92) op = OP_DIAM;
        else                op = OP_UNUSED;
        x      = near_coord(cols_now);
        y      = near_coord(rows_now);
        last_x = x;
        last_y = y;
        return make_cmd(op, x, y, shape_size(), shape_size(), 8'($urandom_range(0, 255)));
    endfunction

    // Probe around the last shape, across the view, or anywhere
    function automatic t_cmd random_read();
        int pick, x, y;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            x = last_x + int'($urandom_range(0, 12)) - 4;
            y = last_y + int'($urandom_range(0, 12)) - 4;
        end else if (pick < 85) begin
            x = int'($urandom_range(0, cols_now + 1)) - 1;
            y = int'($urandom_range(0, rows_now + 1)) - 1;
        end else begin
            x = int'($urandom_range(0, 255)) - 128;
            y = int'($urandom_range(0, 255)) - 128;
        end
        return make_cmd(OP_READ, x, y, $urandom_range(0, 127), $urandom_range(0, 127),
                        8'($urandom_range(0, 255)));
    endfunction

    // Hand one item over, then idle at random
    task automatic issue(input t_cmd c);
        start    <= 1'b1;
        cmd_item <= c;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Hold off until every expected result has come back
    task automatic wait_results_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic idx, input logic wr, input logic [6:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PAW'({idx, 2'b00});
        pwdata  <= {25'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Resize the canvas and read both registers back
    task automatic set_canvas(input int w, input int h);
        apb_access(REG_WIDTH, 1'b1, 7'(w));
        apb_access(REG_HEIGHT, 1'b1, 7'(h));
        apb_access(REG_WIDTH, 1'b0, 7'd0);
        apb_access(REG_HEIGHT, 1'b0, 7'd0);
        cols_now = (w > MAX_COLS) ? MAX_COLS : w;
        rows_now = (h > MAX_ROWS) ? MAX_ROWS : h;
    endtask

    initial begin
        int phase, sent, n, w, h;
        repeat (2) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        idle_pct = 24;

        // Directed items on the reset canvas
        issue(make_cmd(OP_READ, 0, 0, 0, 0, 8'd0));
        issue(make_cmd(OP_READ, 37, 0, 0, 0, 8'd0));
        issue(make_cmd(OP_READ, 0, 64, 0, 0, 8'd0));
        issue(make_cmd(OP_READ, 64, 64, 0, 0, 8'd0));
        issue(make_cmd(OP_READ, 65, 3, 0, 0, 8'd0));
        issue(make_cmd(OP_READ, 3, -1, 0, 0, 8'd0));
        issue(make_cmd(OP_READ, -128, 127, 127, 127, 8'hFF));
        issue(make_cmd(OP_PIXEL, 1, 1, 0, 0, 8'hFF));
        issue(make_cmd(OP_READ, 1, 1, 0, 0, 8'd0));
        issue(make_cmd(OP_PIXEL, 64, 64, 0, 0, 8'h00));
        issue(make_cmd(OP_READ, 64, 64, 0, 0, 8'd0));
        issue(make_cmd(OP_PIXEL, 0, 5, 0, 0, 8'h58));
        issue(make_cmd(OP_PIXEL, -128, -128, 0, 0, 8'h80));
        issue(make_cmd(OP_RECT, -3, -3, 127, 127, 8'h23));
        issue(make_cmd(OP_RECT, 10, 10, 0, 5, 8'h61));
        issue(make_cmd(OP_RECT, 10, 10, 5, 0, 8'h62));
        issue(make_cmd(OP_READ, 11, 11, 0, 0, 8'd0));
        issue(make_cmd(OP_TRIUP, 20, 5, 0, 6, 8'h75));
        issue(make_cmd(OP_READ, 21, 8, 0, 0, 8'd0));
        issue(make_cmd(OP_TRIDN, 30, 40, 0, 127, 8'h64));
        issue(make_cmd(OP_DIAM, 20, 20, 0, 0, 8'h6F));
        issue(make_cmd(OP_READ, 21, 21, 0, 0, 8'd0));
        issue(make_cmd(OP_DIAM, 40, -100, 0, 127, 8'h76));
        issue(make_cmd(OP_UNUSED, 127, 127, 127, 127, 8'hFF));
        issue(make_cmd(OP_READ, 41, 1, 0, 0, 8'd0));
        issue(make_cmd(OP_CLEAR, 0, 0, 0, 0, 8'd0));
        issue(make_cmd(OP_READ, 41, 1, 0, 0, 8'd0));

        // Random phases, each on its own canvas size
        for (phase = 0; phase < 6; phase++) begin
            wait_results_drained();
            case (phase)
                0: begin w = 20;  h = 13;  end
                1: begin w = 0;   h = 127; end
                2: begin w = 127; h = 1;   end
                3: begin w = 1;   h = 0;   end
                4: begin w = 64;  h = 64;  end
                default: begin
                    w = $urandom_range(1, 127);
                    h = $urandom_range(1, 127);
                end
            endcase
            idle_pct = (phase < 2) ? 24 : (phase < 4) ? 74 : 0;
            set_canvas(w, h);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                issue(random_draw());
                sent++;
                n = $urandom_range(1, 3);
                repeat (n) begin
                    issue(random_read());
                    sent++;
                end
            end
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
